[design/btmx_pkg.sv]
// ----------------------------------------------------------------------------
// btmx_pkg
// Shared types and command codes for the binary trie maximum-XOR block.
// ----------------------------------------------------------------------------
package btmx_pkg;

    localparam int CMD_W = 2;
    localparam int KEY_W = 32;

    typedef logic [CMD_W-1:0] cmd_t;
    typedef logic [KEY_W-1:0] key_t;

    localparam cmd_t CMD_INSERT = 2'd0;
    localparam cmd_t CMD_QUERY  = 2'd1;
    localparam cmd_t CMD_CLEAR  = 2'd2;

endpackage

[design/btmx_if.sv]
// ----------------------------------------------------------------------------
// btmx_if
// Valid/ready channels for command items and result items.
// ----------------------------------------------------------------------------
interface btmx_req_if import btmx_pkg::*;;
    logic valid;
    logic ready;
    cmd_t command;
    key_t key;

    modport source (output valid, output command, output key, input ready);
    modport sink   (input valid, input command, input key, output ready);
endinterface

interface btmx_rsp_if import btmx_pkg::*;;
    logic valid;
    logic ready;
    key_t best_xor;
    logic overflow;
    logic empty_res;

    modport source (output valid, output best_xor, output overflow, output empty_res,
                    input ready);
    modport sink   (input valid, input best_xor, input overflow, input empty_res,
                    output ready);
endinterface

[design/binary_trie_max_xor_core.sv]
// ----------------------------------------------------------------------------
// binary_trie_max_xor_core
// Binary trie of keys with insert, maximum-XOR query and clear commands.
// ----------------------------------------------------------------------------
// Usage:
// Command items arrive on req (command, key) and each one gives exactly one
// result item on rsp (best_xor, overflow, empty_res). An item is taken when
// valid and ready are both high at a rising clock edge.
// Insert and query walk up to KEY_BITS trie levels, one level per cycle, with
// one node-table read per level; an overflowing insert or a dead-end query
// stops early. An item is accepted in S_IDLE and its result is registered at
// the end of the walk; a new item is taken only once that result sits in the
// output register. Clear, an unused command, and a query of an empty trie end
// at the first walk step. Reset clears the root links and the node count; the
// table needs no clearing pass, since a handed-out node reads as all zero until
// its insert writes it, and nodes beyond the count are never read.
// The result sits in an output register. While the receiver stalls, the next
// item is still accepted and walked; its finished result waits in a holding
// register, and no new item is taken until the output register frees up.
// ----------------------------------------------------------------------------
module binary_trie_max_xor_core
    import btmx_pkg::*;
#(
    parameter int NODE_COUNT = 65536,
    parameter int KEY_BITS   = 32
) (
    input  logic             clk,
    input  logic             rst_n,
    btmx_req_if.sink         req,
    btmx_rsp_if.source       rsp
);

    localparam int NB = $clog2(NODE_COUNT);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_WALK = 2'd1;
    localparam logic [1:0] S_DONE = 2'd2;

    typedef logic [NB-1:0]       node_t;
    typedef logic [1:0][NB-1:0]  links_t;

    // Node table. Entry 0 is unused: the root links live in registers so that
    // a clear only has to zero those registers and the node count.
    links_t node_mem [NODE_COUNT];
    links_t rdata_reg;

    logic                mem_we;
    node_t               mem_waddr;
    links_t              mem_wdata;
    logic                mem_re;
    node_t               mem_raddr;

    logic [1:0]          state_reg, state_next;
    cmd_t                cmd_reg, cmd_next;
    logic [KEY_BITS-1:0] key_reg, key_next;
    logic [KEY_BITS-1:0] mask_reg, mask_next;
    logic [KEY_BITS-1:0] acc_reg, acc_next;
    node_t               node_reg, node_next;
    logic                fresh_reg, fresh_next;
    links_t              root_reg, root_next;
    node_t               used_reg, used_next;

    key_t                pend_best_reg, pend_best_next;
    logic                pend_ovf_reg, pend_ovf_next;
    logic                pend_emp_reg, pend_emp_next;

    logic                out_valid_reg, out_valid_next;
    key_t                out_best_reg, out_best_next;
    logic                out_ovf_reg, out_ovf_next;
    logic                out_emp_reg, out_emp_next;

    logic                kbit;
    logic                first_lvl;
    logic                last_lvl;
    logic                full;
    node_t               new_node;
    links_t              pair;
    links_t              pair_upd;
    node_t               lnk_b;
    node_t               lnk_o;
    logic                slot_free;

    logic                fin;
    key_t                fin_best;
    logic                fin_ovf;
    logic                fin_emp;

    assign req.ready     = (state_reg == S_IDLE);
    assign rsp.valid     = out_valid_reg;
    assign rsp.best_xor  = out_best_reg;
    assign rsp.overflow  = out_ovf_reg;
    assign rsp.empty_res = out_emp_reg;

    // The walk is driven by a one-hot mask that starts at the key's top bit.
    assign kbit      = |(key_reg & mask_reg);
    assign first_lvl = mask_reg[KEY_BITS-1];
    assign last_lvl  = mask_reg[0];
    assign full      = (used_reg == NB'(NODE_COUNT - 1));
    assign new_node  = used_reg + NB'(1);
    assign slot_free = !out_valid_reg || rsp.ready;

    // Links of the current node: the root registers at the top level, all zero
    // for a node that this insert just handed out, else the table read.
    always_comb
    begin
        if (first_lvl)
        begin
            pair = root_reg;
        end
        else if (fresh_reg)
        begin
            pair = '0;
        end
        else
        begin
            pair = rdata_reg;
        end
    end

    assign lnk_b = pair[kbit];
    assign lnk_o = pair[~kbit];

    always_comb
    begin
        state_next     = state_reg;
        cmd_next       = cmd_reg;
        key_next       = key_reg;
        mask_next      = mask_reg;
        acc_next       = acc_reg;
        node_next      = node_reg;
        fresh_next     = fresh_reg;
        root_next      = root_reg;
        used_next      = used_reg;
        pend_best_next = pend_best_reg;
        pend_ovf_next  = pend_ovf_reg;
        pend_emp_next  = pend_emp_reg;
        out_valid_next = out_valid_reg && !rsp.ready;
        out_best_next  = out_best_reg;
        out_ovf_next   = out_ovf_reg;
        out_emp_next   = out_emp_reg;
        mem_we         = 1'b0;
        mem_waddr      = node_reg;
        mem_wdata      = '0;
        mem_re         = 1'b0;
        mem_raddr      = '0;
        pair_upd       = pair;
        fin            = 1'b0;
        fin_best       = '0;
        fin_ovf        = 1'b0;
        fin_emp        = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    cmd_next   = req.command;
                    key_next   = KEY_BITS'(req.key);
                    mask_next  = {1'b1, {(KEY_BITS-1){1'b0}}};
                    acc_next   = '0;
                    node_next  = '0;
                    fresh_next = 1'b0;
                    state_next = S_WALK;
                end
            end

            S_WALK:
            begin
                mask_next = mask_reg >> 1;
                unique case (cmd_reg)
                    CMD_INSERT:
                    begin
                        if (lnk_b != '0)
                        begin
                            node_next  = lnk_b;
                            fresh_next = 1'b0;
                            mem_re     = 1'b1;
                            mem_raddr  = lnk_b;
                            fin        = last_lvl;
                        end
                        else if (full)
                        begin
                            // Out of nodes: a node handed out on the level
                            // above still holds stale links, so zero it.
                            fin     = 1'b1;
                            fin_ovf = 1'b1;
                            if (fresh_reg)
                            begin
                                mem_we    = 1'b1;
                                mem_wdata = '0;
                            end
                        end
                        else
                        begin
                            used_next      = new_node;
                            pair_upd[kbit] = new_node;
                            if (first_lvl)
                            begin
                                root_next = pair_upd;
                            end
                            else
                            begin
                                mem_we    = 1'b1;
                                mem_wdata = pair_upd;
                            end
                            node_next  = new_node;
                            fresh_next = 1'b1;
                            fin        = last_lvl;
                        end
                    end

                    CMD_QUERY:
                    begin
                        if (first_lvl && root_reg == '0)
                        begin
                            fin     = 1'b1;
                            fin_emp = 1'b1;
                        end
                        else if (lnk_o != '0)
                        begin
                            acc_next  = acc_reg | mask_reg;
                            node_next = lnk_o;
                            mem_re    = 1'b1;
                            mem_raddr = lnk_o;
                            fin       = last_lvl;
                        end
                        else if (lnk_b != '0)
                        begin
                            node_next = lnk_b;
                            mem_re    = 1'b1;
                            mem_raddr = lnk_b;
                            fin       = last_lvl;
                        end
                        else
                        begin
                            // Dead end left by an insert that overflowed.
                            fin = 1'b1;
                        end
                        fin_best = KEY_W'(acc_next);
                    end

                    CMD_CLEAR:
                    begin
                        root_next = '0;
                        used_next = '0;
                        fin       = 1'b1;
                    end

                    default:
                    begin
                        fin = 1'b1;
                    end
                endcase
            end

            S_DONE:
            begin
                fin      = 1'b1;
                fin_best = pend_best_reg;
                fin_ovf  = pend_ovf_reg;
                fin_emp  = pend_emp_reg;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (fin)
        begin
            if (slot_free)
            begin
                out_valid_next = 1'b1;
                out_best_next  = fin_best;
                out_ovf_next   = fin_ovf;
                out_emp_next   = fin_emp;
                state_next     = S_IDLE;
            end
            else
            begin
                pend_best_next = fin_best;
                pend_ovf_next  = fin_ovf;
                pend_emp_next  = fin_emp;
                state_next     = S_DONE;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            root_reg      <= '0;
            used_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            root_reg      <= root_next;
            used_reg      <= used_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg       <= cmd_next;
        key_reg       <= key_next;
        mask_reg      <= mask_next;
        acc_reg       <= acc_next;
        node_reg      <= node_next;
        fresh_reg     <= fresh_next;
        pend_best_reg <= pend_best_next;
        pend_ovf_reg  <= pend_ovf_next;
        pend_emp_reg  <= pend_emp_next;
        out_best_reg  <= out_best_next;
        out_ovf_reg   <= out_ovf_next;
        out_emp_reg   <= out_emp_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            node_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rdata_reg <= node_mem[mem_raddr];
        end
    end

    // The root never lives in the table.
    a_no_root_write: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> mem_waddr != '0)
        else $error("node table write to the root entry");

    // A walk never reads the node it is rewriting.
    a_rw_apart: assert property (@(posedge clk) disable iff (!rst_n)
        (mem_we && mem_re) |-> mem_waddr != mem_raddr)
        else $error("node table read and write hit the same entry");

    // A clear leaves an empty trie behind.
    a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_WALK && cmd_reg == CMD_CLEAR) |=> (root_reg == '0 && used_reg == '0))
        else $error("clear did not empty the trie");

    // Overflow is reported only when every node is taken.
    a_ovf_full: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_WALK && fin && fin_ovf) |-> full)
        else $error("overflow flagged with free nodes left");

endmodule

[tb/sv/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the binary trie maximum-XOR core. A bit-accurate
// trie model predicts every result item, and a monitor compares each result
// field by field under random sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module tb_top;
    import btmx_pkg::*;

    // The bench model uses the same table size and key width as the core.
    localparam int NODES       = 65536;
    localparam int CYCLE_LIMIT = 1500000;
    localparam int RAND_ITEMS  = 400;
    localparam int MAX_REPORTS = 10;
    // Command code 3 has no meaning in the core and must leave the trie alone.
    localparam cmd_t CMD_UNUSED = 2'd3;

    typedef struct {
        cmd_t command;
        key_t key;
    } trie_cmd_t;

    typedef struct {
        key_t best_xor;
        logic overflow;
        logic empty_res;
    } trie_result_t;

    logic clk = 1'b0;
    logic rst_n;

    btmx_req_if req_ch ();
    btmx_rsp_if rsp_ch ();

    binary_trie_max_xor_core #(
        .NODE_COUNT (NODES),
        .KEY_BITS   (KEY_W)
    ) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch.sink),
        .rsp   (rsp_ch.source)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Trie model. Node 0 is the root and a link of 0 means that there is no
    // child, since the root can never be somebody's child.
    // ------------------------------------------------------------------------
    int unsigned trie_link [NODES][2];
    int unsigned node_count = 0;

    trie_cmd_t    cmd_backlog [$];
    trie_result_t owed_results [$];
    key_t         segment_keys [$];

    int n_insert = 0;
    int n_overflow = 0;
    int n_query = 0;
    int n_empty = 0;
    int n_dead_end = 0;
    int n_clear = 0;
    int n_unused = 0;
    int n_checked = 0;
    int mismatches = 0;

    function automatic trie_result_t predict_trie(cmd_t command, key_t key);
        trie_result_t r;
        int unsigned  node;
        int unsigned  nxt;
        int unsigned  opp;
        int unsigned  same;
        int           lvl;
        bit           stop;
        r.best_xor  = '0;
        r.overflow  = 1'b0;
        r.empty_res = 1'b0;
        node = 0;
        stop = 1'b0;
        case (command)
            CMD_INSERT:
            begin
                n_insert++;
                for (lvl = KEY_W - 1; lvl >= 0 && !stop; lvl--)
                begin
                    nxt = trie_link[node][key[lvl]];
                    if (nxt == 0)
                    begin
                        // A new node needs room beyond the root and the
                        // nodes already handed out; nodes placed at higher
                        // levels by this insert stay where they are.
                        if (node_count + 1 >= NODES)
                        begin
                            r.overflow = 1'b1;
                            stop = 1'b1;
                        end
                        else
                        begin
                            node_count++;
                            nxt = node_count;
                            trie_link[node][key[lvl]] = nxt;
                        end
                    end
                    node = nxt;
                end
                if (r.overflow)
                begin
                    n_overflow++;
                end
            end
            CMD_QUERY:
            begin
                n_query++;
                if (trie_link[0][0] == 0 && trie_link[0][1] == 0)
                begin
                    r.empty_res = 1'b1;
                    n_empty++;
                end
                else
                begin
                    for (lvl = KEY_W - 1; lvl >= 0 && !stop; lvl--)
                    begin
                        opp  = trie_link[node][key[lvl] ^ 1'b1];
                        same = trie_link[node][key[lvl]];
                        if (opp != 0)
                        begin
                            r.best_xor[lvl] = 1'b1;
                            node = opp;
                        end
                        else if (same != 0)
                        begin
                            node = same;
                        end
                        else
                        begin
                            // A path cut short by an overflowed insert ends
                            // here, and the lower bits stay zero.
                            stop = 1'b1;
                            n_dead_end++;
                        end
                    end
                end
            end
            CMD_CLEAR:
            begin
                n_clear++;
                for (int unsigned i = 0; i <= node_count; i++)
                begin
                    trie_link[i][0] = 0;
                    trie_link[i][1] = 0;
                end
                node_count = 0;
            end
            default:
            begin
                n_unused++;
            end
        endcase
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Command driver. Items leave the backlog in bursts of random length with
    // random gaps between the bursts. Inputs change on the falling edge.
    // ------------------------------------------------------------------------
    trie_cmd_t cur_item;
    bit        item_held = 1'b0;
    bit        item_taken = 1'b0;
    int        burst_left = 0;
    int        gap_left = 0;

    always @(negedge clk)
    begin
        if (item_taken)
        begin
            item_taken = 1'b0;
            item_held = 1'b0;
        end
        if (rst_n && !item_held && cmd_backlog.size() != 0)
        begin
            if (gap_left != 0)
            begin
                gap_left--;
            end
            else
            begin
                cur_item = cmd_backlog.pop_front();
                item_held = 1'b1;
                if (burst_left <= 1)
                begin
                    // Short gaps, long gaps that outlast a whole walk, and no
                    // gap at all, so that idle time lands on every phase.
                    burst_left = $urandom_range(1, 12);
                    case ($urandom_range(0, 2))
                        0: gap_left = 0;
                        1: gap_left = $urandom_range(1, 8);
                        default: gap_left = $urandom_range(1, 45);
                    endcase
                end
                else
                begin
                    burst_left--;
                end
            end
        end
        req_ch.valid   <= item_held;
        req_ch.command <= cur_item.command;
        req_ch.key     <= cur_item.key;
    end

    // ------------------------------------------------------------------------
    // Result receiver. Ready follows a 12-bit pattern that is replaced when its
    // random age runs out; bit 0 is always set so that no stall lasts forever,
    // and an all-ones pattern now and then gives stretches with no stalls.
    // ------------------------------------------------------------------------
    logic [11:0] stall_pattern = '1;
    int          pattern_age = 0;
    int          pattern_pos = 0;

    always @(negedge clk)
    begin
        if (pattern_age == 0)
        begin
            pattern_age = $urandom_range(40, 200);
            if ($urandom_range(0, 3) == 0)
                stall_pattern = '1;
            else
                stall_pattern = 12'($urandom) | 12'h001;
        end
        pattern_age--;
        rsp_ch.ready <= stall_pattern[pattern_pos];
        pattern_pos = (pattern_pos + 1) % 12;
    end

    // ------------------------------------------------------------------------
    // Monitor. On each rising edge an accepted command item is run through
    // the model, and an accepted result item is checked against the oldest
    // prediction that is still owed.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        trie_result_t want;
        if (rst_n)
        begin
            if (req_ch.valid && req_ch.ready)
            begin
                owed_results.push_back(predict_trie(req_ch.command, req_ch.key));
                item_taken = 1'b1;
            end
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                if (owed_results.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("ERROR: unexpected result best_xor=%h ovf=%b empty=%b",
                                 rsp_ch.best_xor, rsp_ch.overflow, rsp_ch.empty_res);
                end
                else
                begin
                    want = owed_results.pop_front();
                    n_checked++;
                    if (rsp_ch.best_xor !== want.best_xor ||
                        rsp_ch.overflow !== want.overflow ||
                        rsp_ch.empty_res !== want.empty_res)
                    begin
                        mismatches++;
                        if (mismatches <= MAX_REPORTS)
                            $display("ERROR: result %0d: expected %h/%b/%b, got %h/%b/%b",
                                     n_checked, want.best_xor, want.overflow,
                                     want.empty_res, rsp_ch.best_xor,
                                     rsp_ch.overflow, rsp_ch.empty_res);
                    end
                end
            end
        end
    end

    // A hung handshake ends the run here.
    int unsigned cycle_count = 0;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("TIMEOUT after %0d cycles with %0d results owed", cycle_count,
                     owed_results.size());
            $display("Test completed with failures");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus.
    // ------------------------------------------------------------------------
    task automatic push_item(cmd_t command, key_t key);
        cmd_backlog.push_back('{command, key});
        if (command == CMD_INSERT)
            segment_keys.push_back(key);
        else if (command == CMD_CLEAR)
            segment_keys.delete();
    endtask

    // Waits until the sender has nothing left; with all_results set it also
    // waits until every owed result has come back.
    task automatic wait_idle(bit all_results);
        while (cmd_backlog.size() != 0 || item_held ||
               (all_results && owed_results.size() != 0))
            @(posedge clk);
    endtask

    // Keys that sit close to the stored ones make the query walks interesting.
    function automatic key_t pick_key();
        key_t k;
        int   n;
        n = segment_keys.size();
        case ($urandom_range(0, 9))
            4, 5: k = (n != 0) ? segment_keys[$urandom_range(0, n - 1)] ^
                                 (key_t'(1) << $urandom_range(0, KEY_W - 1)) : $urandom;
            6:    k = (n != 0) ? ~segment_keys[$urandom_range(0, n - 1)] : $urandom;
            7:    k = key_t'($urandom_range(0, 15));
            8:    k = 32'hFFFF_FFF0 | key_t'($urandom_range(0, 15));
            9:    k = (n != 0) ? segment_keys[$urandom_range(0, n - 1)] : $urandom;
            default: k = $urandom;
        endcase
        return k;
    endfunction

    initial
    begin
        int   rand_count;
        int   pick;
        key_t k;

        rst_n = 1'b0;
        req_ch.valid = 1'b0;
        req_ch.command = CMD_INSERT;
        req_ch.key = '0;
        rsp_ch.ready = 1'b0;
        cur_item = '{CMD_INSERT, '0};
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed part: the empty trie, the unused command, the extreme keys
        // and a duplicate insert.
        push_item(CMD_QUERY,  32'h0000_0000);
        push_item(CMD_QUERY,  32'hFFFF_FFFF);
        push_item(CMD_CLEAR,  32'hFFFF_FFFF);
        push_item(CMD_UNUSED, 32'hFFFF_FFFF);
        push_item(CMD_INSERT, 32'h0000_0000);
        push_item(CMD_QUERY,  32'h0000_0000);
        push_item(CMD_QUERY,  32'hFFFF_FFFF);
        push_item(CMD_INSERT, 32'hFFFF_FFFF);
        push_item(CMD_QUERY,  32'h0000_0000);
        push_item(CMD_INSERT, 32'h0000_0000);
        push_item(CMD_INSERT, 32'h8000_0000);
        push_item(CMD_INSERT, 32'h0000_0001);
        push_item(CMD_QUERY,  32'h7FFF_FFFF);
        push_item(CMD_QUERY,  32'h5555_5555);
        push_item(CMD_UNUSED, 32'hAAAA_AAAA);
        push_item(CMD_QUERY,  32'hAAAA_AAAA);
        push_item(CMD_CLEAR,  32'h0000_0000);
        push_item(CMD_QUERY,  32'h1234_5678);
        push_item(CMD_INSERT, 32'hDEAD_BEEF);
        push_item(CMD_QUERY,  32'h2152_4110);
        push_item(CMD_QUERY,  32'hDEAD_BEEF);
        push_item(CMD_CLEAR,  32'h0000_0000);

        // Hold the sender until every directed result is back.
        wait_idle(1'b1);

        // Random part: mostly segments that start from a cleared trie, fill
        // it with a handful of keys and then mix queries and more inserts.
        rand_count = 0;
        while (rand_count < RAND_ITEMS)
        begin
            if ($urandom_range(0, 4) != 0)
            begin
                push_item(CMD_CLEAR, $urandom);
                rand_count++;
            end
            repeat ($urandom_range(1, 10))
            begin
                push_item(CMD_INSERT, pick_key());
                rand_count++;
            end
            repeat ($urandom_range(10, 40))
            begin
                pick = $urandom_range(0, 99);
                if (pick < 40)
                    push_item(CMD_INSERT, pick_key());
                else if (pick < 92)
                    push_item(CMD_QUERY, pick_key());
                else if (pick < 96)
                    push_item(CMD_CLEAR, $urandom);
                else
                    push_item(CMD_UNUSED, $urandom);
                rand_count++;
            end
            if ($urandom_range(0, 5) == 0)
                wait_idle(1'b1);
        end

        // A short tail: an unused command, a clear, a query on the emptied
        // trie, and one key queried with its complement.
        push_item(CMD_UNUSED, $urandom);
        push_item(CMD_CLEAR, '0);
        push_item(CMD_QUERY, $urandom);
        k = $urandom;
        push_item(CMD_INSERT, k);
        push_item(CMD_QUERY, ~k);

        // Drain, then let the clock run on so that the core can show any
        // stray result item.
        wait_idle(1'b1);
        repeat (3 * (KEY_W + 1)) @(posedge clk);
        if (owed_results.size() != 0)
        begin
            $display("ERROR: %0d results never arrived", owed_results.size());
            mismatches += owed_results.size();
        end

        $display("Checked %0d results: %0d inserts (%0d out of nodes), %0d queries", n_checked,
                 n_insert, n_overflow, n_query);
        $display("  %0d queries on an empty trie, %0d hit a dead end, %0d clears, %0d unused",
                 n_empty, n_dead_end, n_clear, n_unused);
        if (mismatches == 0)
        begin
            $display("Test completed successfully");
        end
        else
        begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
